>>> design/gbn_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the go-back-n sender window.
package gbn_pkg;

    typedef enum logic [1:0] {
        CMD_START     = 2'd0,
        CMD_SEND_POLL = 2'd1,
        CMD_ACK       = 2'd2,
        CMD_IDLE      = 2'd3
    } gbn_cmd_t;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd2;

    localparam logic [15:0] TOTAL_PACKETS_RESET = 16'd1;
    localparam logic [4:0]  WINDOW_SIZE_RESET   = 5'd10;
    localparam logic [7:0]  TIMEOUT_LIMIT_RESET = 8'd20;

    typedef struct packed {
        logic [15:0] total_packets;
        logic [4:0]  window_size;
        logic [7:0]  timeout_limit;
    } gbn_cfg_t;

    typedef struct packed {
        logic        send_valid;
        logic [4:0]  send_seq;
        logic [15:0] packet_index;
        logic [15:0] acked_total;
        logic        timed_out;
        logic        finished;
    } gbn_result_t;

endpackage

>>> design/gbn_cmd_if.sv
`timescale 1ns / 1ps
// Command channel: valid/ready handshake carrying one command beat.
interface gbn_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [4:0] ack_seq;

    modport source (output valid, output cmd, output ack_seq, input ready);
    modport sink   (input valid, input cmd, input ack_seq, output ready);
endinterface

>>> design/gbn_res_if.sv
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one result beat.
interface gbn_res_if;
    logic        valid;
    logic        ready;
    logic        send_valid;
    logic [4:0]  send_seq;
    logic [15:0] packet_index;
    logic [15:0] acked_total;
    logic        timed_out;
    logic        finished;

    modport source (output valid, output send_valid, output send_seq,
                    output packet_index, output acked_total, output timed_out,
                    output finished, input ready);
    modport sink   (input valid, input send_valid, input send_seq,
                    input packet_index, input acked_total, input timed_out,
                    input finished, output ready);
endinterface

>>> design/go_back_n_sender_window.sv
`timescale 1ns / 1ps
// A command beat is held in the input register; the core steps on it and its result beat
// is loaded into the result register when that register is free or draining.
// One command per cycle unless the result stalls; the core window updates once per step.
// Input register and result register decouple the channels, so a stalled result
// still lets one more command be taken. Reset (async, active low) restores the
// register defaults and an empty window at once; there is no clearing pass.
module go_back_n_sender_window #(
    parameter int SEQ_COUNT = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    gbn_cmd_if.sink                          cmd_ch,
    gbn_res_if.source                        res_ch,
    input  logic                             cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // configuration registers
    gbn_pkg::gbn_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_packets <= gbn_pkg::TOTAL_PACKETS_RESET;
            cfg_reg.window_size   <= gbn_pkg::WINDOW_SIZE_RESET;
            cfg_reg.timeout_limit <= gbn_pkg::TIMEOUT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gbn_pkg::CFG_TOTAL_PACKETS: cfg_reg.total_packets <= cfg_data;
                gbn_pkg::CFG_WINDOW_SIZE:   cfg_reg.window_size   <= cfg_data[4:0];
                gbn_pkg::CFG_TIMEOUT_LIMIT: cfg_reg.timeout_limit <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register: holds one command beat until the core takes it
    logic              in_valid_reg;
    gbn_pkg::gbn_cmd_t cmd_reg;
    logic [4:0]        ack_seq_reg;

    // result register
    logic                 out_valid_reg;
    gbn_pkg::gbn_result_t res_reg;
    gbn_pkg::gbn_result_t core_result;

    logic cmd_fire;
    logic advance;

    // core steps when a command is held and the result slot is free or draining
    assign advance      = in_valid_reg && (!out_valid_reg || res_ch.ready);
    assign cmd_ch.ready = !in_valid_reg || advance;
    assign cmd_fire     = cmd_ch.valid && cmd_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_reg     <= gbn_pkg::gbn_cmd_t'(cmd_ch.cmd);
            ack_seq_reg <= cmd_ch.ack_seq;
        end
    end

    gbn_window_core #(
        .SEQ_COUNT (SEQ_COUNT)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .cmd     (cmd_reg),
        .ack_seq (ack_seq_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= core_result;
        end
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.send_valid   = res_reg.send_valid;
    assign res_ch.send_seq     = res_reg.send_seq;
    assign res_ch.packet_index = res_reg.packet_index;
    assign res_ch.acked_total  = res_reg.acked_total;
    assign res_ch.timed_out    = res_reg.timed_out;
    assign res_ch.finished     = res_reg.finished;

    // a held command with a stalled result beat must block the command channel
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !res_ch.ready) |-> !cmd_ch.ready)
        else $error("command accepted while both stages are full");

    // a grant never coincides with a rewind or a finished transfer
    a_grant_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.send_valid) |->
            (!res_ch.timed_out && !res_ch.finished && res_ch.send_seq != 5'd0))
        else $error("grant beat carries rewind or finish");

    // a rewind beat carries no grant
    a_rewind_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (res_ch.valid && res_ch.timed_out) |->
            (!res_ch.send_valid && res_ch.send_seq == 5'd0))
        else $error("rewind beat carries a sequence number");

    // a new result beat only comes from a held command
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg == 1'b0 && !out_valid_reg) |=> !out_valid_reg)
        else $error("result beat without a command");

endmodule

>>> design/gbn_window_core.sv
`timescale 1ns / 1ps
// Window state and combinational command update for the go-back-n sender.
module gbn_window_core #(
    parameter int SEQ_COUNT = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  gbn_pkg::gbn_cmd_t   cmd,
    input  logic [4:0]          ack_seq,
    input  gbn_pkg::gbn_cfg_t   cfg,
    output gbn_pkg::gbn_result_t result
);

    localparam int SW = $clog2(SEQ_COUNT);
    localparam int AW = (SW > 5) ? SW : 5;
    localparam int XW = AW + 1;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SEQ_COUNT - 1);

    // (a - b) mod SEQ_COUNT, both inputs below SEQ_COUNT
    function automatic logic [SW-1:0] ring_diff(input logic [SW-1:0] a,
                                                input logic [SW-1:0] b);
        logic [SW:0] t;
        t = {1'b0, a} + (SW+1)'(SEQ_COUNT) - {1'b0, b};
        if (t >= (SW+1)'(SEQ_COUNT))
        begin
            t = t - (SW+1)'(SEQ_COUNT);
        end
        return t[SW-1:0];
    endfunction

    logic [SEQ_COUNT-1:0] slot_free_reg, slot_free_next;
    logic [SW-1:0]        next_slot_reg, next_slot_next;
    logic [SW-1:0]        base_slot_reg, base_slot_next;
    logic [15:0]          sent_count_reg, sent_count_next;
    logic [15:0]          acked_count_reg, acked_count_next;
    logic [7:0]           wait_count_reg, wait_count_next;
    logic                 done_reg, done_next;

    logic [SW-1:0]        outstanding;
    logic [XW-1:0]        win_eff;
    logic                 grant_ok;
    logic                 ack_ok;
    logic [AW-1:0]        ack_m1;
    logic [SW-1:0]        ack_idx;
    logic [SW-1:0]        ack_dist;
    logic                 ack_take;
    logic [15:0]          acked_plus;
    logic [SEQ_COUNT-1:0] free_mask;
    logic [8:0]           wait_inc;
    logic                 wait_over;
    logic [15:0]          rewind_sent;

    assign outstanding = ring_diff(next_slot_reg, base_slot_reg);
    assign win_eff = (XW'(cfg.window_size) > XW'(SEQ_COUNT - 1)) ?
                     XW'(SEQ_COUNT - 1) : XW'(cfg.window_size);
    assign grant_ok = !done_reg && (XW'(outstanding) < win_eff) &&
                      slot_free_reg[next_slot_reg] &&
                      (sent_count_reg < cfg.total_packets);

    assign ack_ok   = (ack_seq != 5'd0) && (XW'(ack_seq) <= XW'(SEQ_COUNT));
    assign ack_m1   = AW'(ack_seq) - AW'(1);
    assign ack_idx  = ack_m1[SW-1:0];
    assign ack_dist = ring_diff(ack_idx, base_slot_reg);
    // duplicate of base-1 lands at distance SEQ_COUNT-1, never below outstanding
    assign ack_take = ack_ok && (ack_dist < outstanding);
    assign acked_plus = acked_count_reg + 16'(ack_dist) + 16'd1;

    always_comb
    begin
        for (int i = 0; i < SEQ_COUNT; i++)
        begin
            free_mask[i] = (ring_diff(SW'(i), base_slot_reg) <= ack_dist);
        end
    end

    assign wait_inc    = {1'b0, wait_count_reg} + 9'd1;
    assign wait_over   = wait_inc > {1'b0, cfg.timeout_limit};
    assign rewind_sent = (sent_count_reg >= 16'(outstanding)) ?
                         sent_count_reg - 16'(outstanding) : 16'd0;

    always_comb
    begin
        slot_free_next   = slot_free_reg;
        next_slot_next   = next_slot_reg;
        base_slot_next   = base_slot_reg;
        sent_count_next  = sent_count_reg;
        acked_count_next = acked_count_reg;
        wait_count_next  = wait_count_reg;
        done_next        = done_reg;
        result           = '0;

        unique case (cmd)
            gbn_pkg::CMD_START:
            begin
                slot_free_next   = '1;
                next_slot_next   = '0;
                base_slot_next   = '0;
                sent_count_next  = '0;
                acked_count_next = '0;
                wait_count_next  = '0;
                done_next        = 1'b0;
            end
            gbn_pkg::CMD_SEND_POLL:
            begin
                if (grant_ok)
                begin
                    result.send_valid   = 1'b1;
                    result.send_seq     = 5'(XW'(next_slot_reg) + XW'(1));
                    result.packet_index = sent_count_reg;
                    slot_free_next[next_slot_reg] = 1'b0;
                    next_slot_next  = (next_slot_reg == LAST_SLOT) ?
                                      '0 : next_slot_reg + SW'(1);
                    sent_count_next = sent_count_reg + 16'd1;
                end
            end
            gbn_pkg::CMD_ACK:
            begin
                if (!done_reg)
                begin
                    wait_count_next = '0;
                    if (ack_take)
                    begin
                        slot_free_next   = slot_free_reg | free_mask;
                        base_slot_next   = (ack_idx == LAST_SLOT) ?
                                           '0 : ack_idx + SW'(1);
                        acked_count_next = acked_plus;
                    end
                    done_next = (acked_count_next >= cfg.total_packets);
                end
            end
            gbn_pkg::CMD_IDLE:
            begin
                if (!done_reg)
                begin
                    if (wait_over)
                    begin
                        wait_count_next = '0;
                        if ((sent_count_reg >= cfg.total_packets) &&
                            (next_slot_reg == base_slot_reg))
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            sent_count_next     = rewind_sent;
                            slot_free_next      = '1;
                            next_slot_next      = base_slot_reg;
                            result.timed_out    = 1'b1;
                            result.packet_index = rewind_sent;
                        end
                    end
                    else
                    begin
                        wait_count_next = wait_inc[7:0];
                    end
                end
            end
            default:
            begin
            end
        endcase

        result.acked_total = acked_count_next;
        result.finished    = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_free_reg   <= '1;
            next_slot_reg   <= '0;
            base_slot_reg   <= '0;
            sent_count_reg  <= '0;
            acked_count_reg <= '0;
            wait_count_reg  <= '0;
            done_reg        <= 1'b0;
        end
        else if (step)
        begin
            slot_free_reg   <= slot_free_next;
            next_slot_reg   <= next_slot_next;
            base_slot_reg   <= base_slot_next;
            sent_count_reg  <= sent_count_next;
            acked_count_reg <= acked_count_next;
            wait_count_reg  <= wait_count_next;
            done_reg        <= done_next;
        end
    end

endmodule
